// ===== rtl/lcdnw_pkg.sv =====
// Shared types, constants and sequencing tables for the character LCD nibble write sequencer.
package lcdnw_pkg;

    // command codes on the request side
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_INIT   = 2'd1;
    localparam logic [1:0] CMD_CURSOR = 2'd2;

    // display lines that a cursor command acts on
    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SHORT  = 2'd0;
    localparam logic [1:0] REG_INIT   = 2'd1;
    localparam logic [1:0] REG_SETTLE = 2'd2;

    localparam logic [15:0] SHORT_HOLD_RST  = 16'd50;
    localparam logic [15:0] INIT_HOLD_RST   = 16'd20000;
    localparam logic [15:0] SETTLE_HOLD_RST = 16'd10000;

    // set DDRAM address command bases
    localparam logic [7:0] LINE_ONE_BASE = 8'h80;
    localparam logic [7:0] LINE_TWO_BASE = 8'hC0;

    // init byte commands
    localparam logic [7:0] INIT_FUNC_SET = 8'h28;
    localparam logic [7:0] INIT_DISP_ON  = 8'h0C;
    localparam logic [7:0] INIT_ENTRY    = 8'h06;
    localparam logic [7:0] INIT_CLEAR    = 8'h01;

    // wake-up nibbles
    localparam logic [3:0] WAKE_NIB  = 4'h3;
    localparam logic [3:0] FOUR_NIB  = 4'h2;

    // pin states per byte, in the init preamble and per full init
    localparam int BYTE_STEPS = 6;
    localparam int PRE_STEPS  = 9;
    localparam int INIT_STEPS = 33;

    localparam int QUEUE_DEPTH_DEF = 4;

    // one unit of work for the back end
    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] byte_val;
    } job_t;

    typedef struct packed {
        logic [15:0] short_hold;
        logic [15:0] init_hold;
        logic [15:0] settle_hold;
    } hold_cfg_t;

    typedef struct packed {
        logic [3:0] nib;
        logic       en;
        logic       use_settle;
    } pre_t;

    // wake-up preamble: nibble 3 pulsed three times, settle, then nibble 2 pulsed
    function automatic pre_t init_pre(input logic [3:0] idx);
        pre_t p;
        p.nib        = WAKE_NIB;
        p.en         = ~idx[0];
        p.use_settle = 1'b0;
        case (idx)
            4'd6: begin
                p.nib = FOUR_NIB;
                p.en  = 1'b0;
                p.use_settle = 1'b1;
            end
            4'd7: begin
                p.nib = FOUR_NIB;
                p.en  = 1'b1;
            end
            4'd8: begin
                p.nib = FOUR_NIB;
                p.en  = 1'b0;
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = INIT_FUNC_SET;
            2'd1:    b = INIT_DISP_ON;
            2'd2:    b = INIT_ENTRY;
            default: b = INIT_CLEAR;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/lcdnw_front.sv =====
// Front end: accepts command requests, drops the ones that act on nothing, builds jobs.
module lcdnw_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // data_byte[7:0], line_no[9:8], column[14:10]
    input  logic [2:0]         s_tuser,   // cmd[1:0], is_char[2]
    output logic               job_valid,
    output lcdnw_pkg::job_t    job,
    input  logic               job_ready
);
    import lcdnw_pkg::*;

    logic       valid_reg, valid_next;
    job_t       job_reg, job_next;
    logic       keep;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       is_char;
    logic [1:0] line_no;
    logic [4:0] column;

    assign cmd       = s_tuser[1:0];
    assign is_char   = s_tuser[2];
    assign data_byte = s_tdata[7:0];
    assign line_no   = s_tdata[9:8];
    assign column    = s_tdata[14:10];

    // classify the request
    always_comb begin
        keep              = 1'b0;
        job_next.init     = 1'b0;
        job_next.rs       = 1'b0;
        job_next.byte_val = data_byte;
        case (cmd)
            CMD_WRITE: begin
                keep        = 1'b1;
                job_next.rs = is_char;
            end
            CMD_INIT: begin
                keep          = 1'b1;
                job_next.init = 1'b1;
            end
            CMD_CURSOR: begin
                if (line_no == LINE_ONE) begin
                    keep = 1'b1;
                    job_next.byte_val = 8'(LINE_ONE_BASE + {3'b000, column} - 8'd1);
                end else if (line_no == LINE_TWO) begin
                    keep = 1'b1;
                    job_next.byte_val = 8'(LINE_TWO_BASE + {3'b000, column} - 8'd1);
                end
            end
            default: ;
        endcase
    end

    assign s_tready = !valid_reg || job_ready;

    // single holding stage in front of the queue
    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = keep;
        end else if (job_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

// ===== rtl/lcdnw_queue.sv =====
// Short job queue between the front end and the pin sequencer.
module lcdnw_queue #(
    parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  lcdnw_pkg::job_t    push_job,
    output logic               push_ready,
    output logic               pop_valid,
    output lcdnw_pkg::job_t    pop_job,
    input  logic               pop
);
    import lcdnw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill count update
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wptr_reg + 1'b1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = CW'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/lcdnw_back.sv =====
// Back end: expands the job at the queue head into timed pin states, one per cycle while the output is not stalled.
module lcdnw_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcdnw_pkg::hold_cfg_t cfg,
    input  logic                 job_valid,
    input  lcdnw_pkg::job_t      job,
    output logic                 job_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // data_pins[3:0], enable_pin[4], hold_us[20:5]
    output logic [0:0]           m_tuser,   // rs_pin[0]
    output logic                 m_tlast
);
    import lcdnw_pkg::*;

    logic [5:0]  step_reg, step_next;
    logic [2:0]  sub_reg, sub_next;
    logic [1:0]  bidx_reg, bidx_next;
    logic        valid_reg;
    logic [3:0]  nib_reg;
    logic        en_reg, rs_reg, last_reg;
    logic [15:0] hold_reg;

    logic        adv, in_pre, is_last;
    pre_t        pre;
    logic [7:0]  cur_byte;
    logic [16:0] end_sum;
    logic [15:0] end_hold;
    logic [3:0]  nib;
    logic        en, rs;
    logic [15:0] hold;

    assign adv     = job_valid && (!valid_reg || m_tready);
    assign in_pre  = job.init && (step_reg < 6'(PRE_STEPS));
    assign pre     = init_pre(step_reg[3:0]);
    assign is_last = job.init ? (step_reg == 6'(INIT_STEPS - 1))
                              : (sub_reg == 3'(BYTE_STEPS - 1));
    assign job_pop = adv && is_last;

    // last init state holds for short plus settle, saturated
    assign end_sum  = {1'b0, cfg.short_hold} + {1'b0, cfg.settle_hold};
    assign end_hold = end_sum[16] ? 16'hFFFF : end_sum[15:0];

    // pin state for the current step
    always_comb begin
        cur_byte = job.init ? init_byte(bidx_reg) : job.byte_val;
        rs       = job.init ? 1'b0 : job.rs;
        if (in_pre) begin
            nib  = pre.nib;
            en   = pre.en;
            hold = pre.use_settle ? cfg.settle_hold : cfg.init_hold;
        end else begin
            nib  = (sub_reg < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
            en   = (sub_reg == 3'd1) || (sub_reg == 3'd4);
            hold = (job.init && is_last) ? end_hold : cfg.short_hold;
        end
    end

    // step counters: preamble steps, then six states per byte
    always_comb begin
        step_next = step_reg;
        sub_next  = sub_reg;
        bidx_next = bidx_reg;
        if (adv) begin
            if (is_last) begin
                step_next = '0;
                sub_next  = '0;
                bidx_next = '0;
            end else begin
                step_next = 6'(step_reg + 1'b1);
                if (!in_pre) begin
                    if (sub_reg == 3'(BYTE_STEPS - 1)) begin
                        sub_next  = '0;
                        bidx_next = 2'(bidx_reg + 1'b1);
                    end else begin
                        sub_next = 3'(sub_reg + 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            sub_reg   <= '0;
            bidx_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            sub_reg  <= sub_next;
            bidx_reg <= bidx_next;
            if (adv) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            nib_reg  <= nib;
            en_reg   <= en;
            rs_reg   <= rs;
            hold_reg <= hold;
            last_reg <= is_last;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {3'b000, hold_reg, en_reg, nib_reg};
    assign m_tuser[0] = rs_reg;
    assign m_tlast    = last_reg;

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer_top.sv =====
// Top level of the character LCD nibble write sequencer: register port, front end, queue, back end.
//
// Takes command requests (byte write, power-up init, cursor position) and turns each into
// the list of 4-bit bus pin states with their hold times. A request is classified in the cycle
// it is accepted; cursor requests on a line other than 1 or 2 and the unused command
// code are dropped and use no sequencer time. Kept jobs wait in a queue of QUEUE_DEPTH
// entries. The pin sequencer emits one pin state per cycle through its output register while
// the result side keeps up, so a byte write or cursor command is 6 pin states and an init is
// 33, sent back to back with the next job; the number of pin states in a job sets the rate.
// Write holding registers via the register port only while idle; the block does not enforce it.
module char_lcd_nibble_write_sequencer_top #(
    parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], line_no[9:8], column[14:10]
    input  logic [2:0]  s_tuser,   // cmd[1:0], is_char[2]
    // pin state channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_pins[3:0], enable_pin[4], hold_us[20:5]
    output logic [0:0]  m_tuser,   // rs_pin[0]
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdnw_pkg::*;

    logic [15:0] short_hold_reg, init_hold_reg, settle_hold_reg;
    logic        cfg_wr;
    hold_cfg_t   cfg;
    logic        f_valid, f_ready;
    job_t        f_job;
    logic        q_valid, q_pop;
    job_t        q_job;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_hold_reg  <= SHORT_HOLD_RST;
            init_hold_reg   <= INIT_HOLD_RST;
            settle_hold_reg <= SETTLE_HOLD_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SHORT:  short_hold_reg  <= pwdata[15:0];
                REG_INIT:   init_hold_reg   <= pwdata[15:0];
                REG_SETTLE: settle_hold_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SHORT:  prdata = {16'd0, short_hold_reg};
            REG_INIT:   prdata = {16'd0, init_hold_reg};
            REG_SETTLE: prdata = {16'd0, settle_hold_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.short_hold  = short_hold_reg;
    assign cfg.init_hold   = init_hold_reg;
    assign cfg.settle_hold = settle_hold_reg;

    lcdnw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (f_valid),
        .job       (f_job),
        .job_ready (f_ready)
    );

    lcdnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_job   (f_job),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_job    (q_job),
        .pop        (q_pop)
    );

    lcdnw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job_valid (q_valid),
        .job       (q_job),
        .job_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // enable high is always followed at once by enable low within the same job
    a_en_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[4] |=> m_tvalid && !m_tdata[4])
        else $error("enable high not followed by enable low");

    // a job never ends on a raised enable
    a_last_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[4])
        else $error("job ended with enable high");

    // a job is only taken from the queue when it is there
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

// ===== test/char_lcd_nibble_write_sequencer_top_test.sv =====
// Testbench for the character LCD nibble write sequencer: stream stimulus, pin state checking.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_top_test;
    import lcdnw_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 48;   // idle margin after the last expected pin state has been seen
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_PHASES = 8;
    localparam int RAND_PER_PHASE = 65;

    // codes the block has to drop
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] LINE_NONE  = 2'd0;
    localparam logic [1:0] LINE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       is_char;
        logic [1:0] line;
        logic [4:0] column;
    } lcd_req_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic        en;
        logic [15:0] hold;
        logic        last;
    } pin_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // requests waiting for the driver, and pin states waiting for the monitor
    lcd_req_t   req_pending[$];
    pin_state_t pin_expect[$];
    int         reqs_open = 0;
    int         fail_count = 0;

    // idling knobs, set per phase
    int gap_max = 0;
    int stall_max = 0;

    // predictor copy of registers
    logic [15:0] short_us  = SHORT_HOLD_RST;
    logic [15:0] init_us   = INIT_HOLD_RST;
    logic [15:0] settle_us = SETTLE_HOLD_RST;
    pin_state_t  seq_buf[INIT_STEPS];
    int          seq_len;

    char_lcd_nibble_write_sequencer_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ---- pin sequence predictor ----
    function automatic void put_pin(input logic rs, input logic [3:0] nib, input logic en,
                                    input logic [15:0] hold);
        pin_state_t p;
        p.rs   = rs;
        p.nib  = nib;
        p.en   = en;
        p.hold = hold;
        p.last = 1'b0;
        seq_buf[seq_len] = p;
        seq_len++;
    endfunction

    function automatic void put_nibble(input logic rs, input logic [3:0] nib);
        put_pin(rs, nib, 1'b0, short_us);
        put_pin(rs, nib, 1'b1, short_us);
        put_pin(rs, nib, 1'b0, short_us);
    endfunction

    function automatic void put_byte(input logic rs, input logic [7:0] b);
        put_nibble(rs, b[7:4]);
        put_nibble(rs, b[3:0]);
    endfunction

    function automatic void wake_pulse(input logic [3:0] nib);
        put_pin(1'b0, nib, 1'b1, init_us);
        put_pin(1'b0, nib, 1'b0, init_us);
    endfunction

    function automatic void predict_pins(input lcd_req_t r);
        int unsigned end_hold;
        seq_len = 0;
        case (r.cmd)
            CMD_WRITE: begin
                put_byte(r.is_char, r.data);
            end
            CMD_INIT: begin
                wake_pulse(WAKE_NIB);
                wake_pulse(WAKE_NIB);
                wake_pulse(WAKE_NIB);
                put_pin(1'b0, FOUR_NIB, 1'b0, settle_us);
                wake_pulse(FOUR_NIB);
                put_byte(1'b0, INIT_FUNC_SET);
                put_byte(1'b0, INIT_DISP_ON);
                put_byte(1'b0, INIT_ENTRY);
                put_byte(1'b0, INIT_CLEAR);
                // clear needs the settle time on top, saturated
                end_hold = 32'(short_us) + 32'(settle_us);
                if (end_hold > 32'hFFFF)
                    end_hold = 32'hFFFF;
                seq_buf[seq_len - 1].hold = end_hold[15:0];
            end
            CMD_CURSOR: begin
                // column taken as given, wraps modulo 256
                if (r.line == LINE_ONE)
                    put_byte(1'b0, LINE_ONE_BASE + {3'd0, r.column} - 8'd1);
                else if (r.line == LINE_TWO)
                    put_byte(1'b0, LINE_TWO_BASE + {3'd0, r.column} - 8'd1);
            end
            default: ;
        endcase
        if (seq_len > 0)
            seq_buf[seq_len - 1].last = 1'b1;
        for (int i = 0; i < seq_len; i++)
            pin_expect.push_back(seq_buf[i]);
    endfunction

    // ---- request driver: bursts with random gaps ----
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge aclk) begin
        lcd_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (req_pending.size() != 0) begin
                r = req_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, r.column, r.line, r.data};
                s_tuser  <= {r.is_char, r.cmd};
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---- result side ready pattern ----
    int rdy_run = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rdy_run > 0) begin
            rdy_run--;
        end else if (stall_max == 0) begin
            m_tready <= 1'b1;
            rdy_run = $urandom_range(1, 30);
        end else if (m_tready) begin
            m_tready <= 1'b0;
            rdy_run = $urandom_range(0, stall_max);
        end else begin
            m_tready <= 1'b1;
            rdy_run = $urandom_range(0, 12);
        end
    end

    // ---- monitor: predict on request, check on pin state ----
    always @(posedge aclk) begin
        lcd_req_t   r;
        pin_state_t want;
        pin_state_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                r.cmd     = s_tuser[1:0];
                r.is_char = s_tuser[2];
                r.data    = s_tdata[7:0];
                r.line    = s_tdata[9:8];
                r.column  = s_tdata[14:10];
                predict_pins(r);
                reqs_open--;
            end
            if (m_tvalid && m_tready) begin
                got.rs   = m_tuser[0];
                got.nib  = m_tdata[3:0];
                got.en   = m_tdata[4];
                got.hold = m_tdata[20:5];
                got.last = m_tlast;
                if (pin_expect.size() == 0) begin
                    $display("%0t: unexpected pin state rs=%0d d=%h en=%0d hold=%0d last=%0d",
                             $time, got.rs, got.nib, got.en, got.hold, got.last);
                    fail_count++;
                end else begin
                    want = pin_expect.pop_front();
                    if (got !== want) begin
                        $write("%0t: pin state mismatch: expected rs=%0d d=%h en=%0d ",
                               $time, want.rs, want.nib, want.en);
                        $write("hold=%0d last=%0d, ", want.hold, want.last);
                        $display("got rs=%0d d=%h en=%0d hold=%0d last=%0d",
                                 got.rs, got.nib, got.en, got.hold, got.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ---- watchdog on handshake activity ----
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("char_lcd_nibble_write_sequencer_top verification failed");
                $finish;
            end
        end
    end

    // ---- stimulus helpers ----
    function automatic void push_req(input logic [1:0] cmd, input logic [7:0] data,
                                     input logic is_char, input logic [1:0] line,
                                     input logic [4:0] column);
        lcd_req_t r;
        r.cmd     = cmd;
        r.data    = data;
        r.is_char = is_char;
        r.line    = line;
        r.column  = column;
        req_pending.push_back(r);
        reqs_open++;
    endfunction

    function automatic void push_random_req();
        int unsigned pick;
        logic [1:0]  cmd;
        logic [1:0]  line;
        logic [4:0]  column;
        pick   = $urandom_range(0, 99);
        line   = 2'($urandom_range(0, 3));
        column = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 16))
                                              : 5'($urandom_range(0, 31));
        if (pick < 55) begin
            cmd = CMD_WRITE;
        end else if (pick < 64) begin
            cmd = CMD_INIT;
        end else if (pick < 88) begin
            cmd  = CMD_CURSOR;
            line = ($urandom_range(0, 1) != 0) ? LINE_TWO : LINE_ONE;
        end else if (pick < 95) begin
            cmd  = CMD_CURSOR;
            line = ($urandom_range(0, 1) != 0) ? LINE_SPARE : LINE_NONE;
        end else begin
            cmd = CMD_UNUSED;
        end
        push_req(cmd, 8'($urandom), 1'($urandom), line, column);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SHORT:  short_us  = val;
            REG_INIT:   init_us   = val;
            REG_SETTLE: settle_us = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (reqs_open != 0 || pin_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---- phases: register setting, idling style, requests ----
    initial begin
        logic [15:0] split;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                1: begin   // minimum holds
                    write_reg(REG_SHORT, 16'd1);
                    write_reg(REG_INIT, 16'd1);
                    write_reg(REG_SETTLE, 16'd1);
                    gap_max = 4;  stall_max = 6;
                end
                2: begin   // maximum holds, init end saturates
                    write_reg(REG_SHORT, 16'hFFFF);
                    write_reg(REG_INIT, 16'hFFFF);
                    write_reg(REG_SETTLE, 16'hFFFF);
                    gap_max = 0;  stall_max = 0;
                end
                3: begin
                    write_reg(REG_SHORT, 16'($urandom));
                    write_reg(REG_INIT, 16'($urandom));
                    write_reg(REG_SETTLE, 16'($urandom));
                    gap_max = 12; stall_max = 20;
                end
                4: begin   // zero holds pass through
                    write_reg(REG_SHORT, 16'd0);
                    write_reg(REG_INIT, 16'd0);
                    write_reg(REG_SETTLE, 16'd0);
                    gap_max = 1;  stall_max = 1;
                end
                5: begin   // init end sum lands exactly on the ceiling
                    split = 16'($urandom_range(1, 65534));
                    write_reg(REG_SHORT, split);
                    write_reg(REG_SETTLE, 16'hFFFF - split);
                    write_reg(REG_INIT, 16'($urandom));
                    gap_max = 6;  stall_max = 2;
                end
                6: begin
                    write_reg(REG_SHORT, 16'($urandom_range(1, 100)));
                    write_reg(REG_INIT, 16'($urandom_range(1, 100)));
                    write_reg(REG_SETTLE, 16'($urandom_range(1, 100)));
                    gap_max = 0;  stall_max = 0;
                end
                7: begin
                    write_reg(REG_SHORT, 16'($urandom));
                    write_reg(REG_INIT, 16'($urandom));
                    write_reg(REG_SETTLE, 16'($urandom));
                    gap_max = 3;  stall_max = 10;
                end
                default: begin
                    gap_max = 2;  stall_max = 3;
                end
            endcase

            if (ph == 0) begin
                // directed: field extremes, all commands, drops and column wrap
                push_req(CMD_WRITE, 8'h00, 1'b0, LINE_NONE, 5'd0);
                push_req(CMD_WRITE, 8'hFF, 1'b1, LINE_SPARE, 5'd31);
                push_req(CMD_WRITE, 8'hA5, 1'b0, LINE_ONE, 5'd1);
                push_req(CMD_WRITE, 8'h5A, 1'b1, LINE_TWO, 5'd16);
                push_req(CMD_INIT, 8'hFF, 1'b1, LINE_SPARE, 5'd31);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_ONE, 5'd1);
                push_req(CMD_CURSOR, 8'hFF, 1'b1, LINE_ONE, 5'd16);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_TWO, 5'd1);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_TWO, 5'd16);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_ONE, 5'd0);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_TWO, 5'd0);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_TWO, 5'd31);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_NONE, 5'd5);
                push_req(CMD_CURSOR, 8'h00, 1'b0, LINE_SPARE, 5'd5);
                push_req(CMD_UNUSED, 8'hFF, 1'b1, LINE_ONE, 5'd3);
                push_req(CMD_WRITE, 8'h48, 1'b1, LINE_NONE, 5'd0);
                push_req(CMD_INIT, 8'h00, 1'b0, LINE_NONE, 5'd0);
                push_req(CMD_UNUSED, 8'h00, 1'b0, LINE_TWO, 5'd1);
                push_req(CMD_WRITE, 8'h0F, 1'b1, LINE_NONE, 5'd0);
            end else begin
                for (int i = 0; i < RAND_PER_PHASE; i++)
                    push_random_req();
            end
        end

        wait_idle();
        if (fail_count == 0 && pin_expect.size() == 0)
            $display("char_lcd_nibble_write_sequencer_top verification clean");
        else
            $display("char_lcd_nibble_write_sequencer_top verification failed");
        $finish;
    end

endmodule
